/* sv/scfp_pkg.sv */
// Shared types, codes and helper functions for the serial command frame parser.
// No dependencies; every other file imports this package.
package scfp_pkg;

   localparam int DEF_COMMAND_LENGTH = 7;
   localparam int DEF_SIZE_DIGITS    = 2;
   localparam logic [7:0] DEF_MAX_DATA_LENGTH = 8'd247;

   typedef enum logic [2:0] {
      PH_CMD  = 3'd0,
      PH_FLAG = 3'd1,
      PH_SIZE = 3'd2,
      PH_SEP  = 3'd3,
      PH_DATA = 3'd4,
      PH_TERM = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY    = 3'd0,
      ST_OK      = 3'd1,
      ST_TIMEOUT = 3'd2,
      ST_BADSIZE = 3'd3,
      ST_NOTERM  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SZ_FIRST  = 2'd0,
      SZ_SIGNED = 2'd1,
      SZ_DIGITS = 2'd2,
      SZ_STOP   = 2'd3
   } size_mode_type;

   typedef enum logic {
      CMD_BYTE    = 1'b0,
      CMD_TIMEOUT = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic [8:0] position;
      logic       frame_end;
      status_type status;
      logic [8:0] frame_length;
   } rsp_type;

   typedef struct packed {
      phase_type     phase;
      logic [8:0]    byte_count;
      logic [7:0]    size_value;
      size_mode_type size_mode;
   } state_type;

   // Returns the digit value in the low four bits and a valid flag on top.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] result;
      result = 5'd0;
      if (c >= "0" && c <= "9") begin
         result = {1'b1, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         result = {1'b1, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         result = {1'b1, 4'(c - "A" + 8'd10)};
      end
      return result;
   endfunction

endpackage

/* sv/serial_command_frame_parser.sv */
// Top level of the serial command frame parser: state register, size limit register,
// the per-beat decoder and the result buffer. Depends on scfp_pkg, scfp_step, scfp_skid.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_stall   | req_data  (req_type)
//   rsp     | out       | rsp_valid / rsp_stall   | rsp_data  (rsp_type)
//   csr     | in        | csr_write_enable        | csr_write_data (max data length)
//
// One beat is accepted per cycle while req_stall is low; its result is registered.
// The rate is set by the single decode step between the parser state and the result register.
// Reset is synchronous and returns the parser to the start of a frame with the limit at 247.
// A stalled result waits in the output register while one more beat lands in the skid
// register; req_stall rises only when the skid register is full.
module serial_command_frame_parser
   import scfp_pkg::*;
#(
   parameter int COMMAND_LENGTH = DEF_COMMAND_LENGTH,
   parameter int SIZE_DIGITS    = DEF_SIZE_DIGITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  req_type    req_data,
   output logic       req_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       rsp_stall,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   state_type  state_ff, state_in;
   logic [7:0] max_len_ff;
   rsp_type    step_rsp;
   logic       step_present;
   logic       req_accept;

   assign req_accept = req_valid && !req_stall;

   scfp_step #(
      .COMMAND_LENGTH (COMMAND_LENGTH),
      .SIZE_DIGITS    (SIZE_DIGITS)
   ) u_step (
      .state           (state_ff),
      .req             (req_data),
      .max_data_length (max_len_ff),
      .state_next      (state_in),
      .rsp             (step_rsp),
      .rsp_present     (step_present)
   );

   scfp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept && step_present),
      .in_data   (step_rsp),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_CMD;
         state_ff.byte_count <= 9'd0;
         state_ff.size_value <= 8'd0;
         state_ff.size_mode  <= SZ_FIRST;
         max_len_ff          <= DEF_MAX_DATA_LENGTH;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         if (csr_write_enable) begin
            max_len_ff <= csr_write_data;
         end
      end
   end

   a_end_has_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.frame_end == (rsp_data.status != ST_BUSY)))
      else $error("frame end flag and status disagree");

   a_length_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.frame_length == 9'd0))
      else $error("frame length set on a result that is not ok");

   a_timeout_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.cmd == CMD_TIMEOUT) |=>
         (state_ff.phase == PH_CMD && state_ff.byte_count == 9'd0))
      else $error("timeout beat did not restart the parser");

   a_count_advances: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !step_rsp.frame_end) |=>
         (state_ff.byte_count == $past(state_ff.byte_count) + 9'd1))
      else $error("byte position did not advance on an accepted beat");

endmodule

/* sv/scfp_step.sv */
// Per-beat frame decoding: next parser state and the result for one input beat.
// Pure combinational logic; depends on scfp_pkg.
module scfp_step
   import scfp_pkg::*;
#(
   parameter int COMMAND_LENGTH = DEF_COMMAND_LENGTH,
   parameter int SIZE_DIGITS    = DEF_SIZE_DIGITS
) (
   input  state_type  state,
   input  req_type    req,
   input  logic [7:0] max_data_length,
   output state_type  state_next,
   output rsp_type    rsp,
   output logic       rsp_present
);

   localparam logic [8:0] CMD_LAST   = 9'(COMMAND_LENGTH - 1);
   localparam logic [8:0] SIZE_LAST  = 9'(COMMAND_LENGTH + SIZE_DIGITS);
   localparam logic [9:0] DATA_BASE  = 10'(COMMAND_LENGTH + SIZE_DIGITS + 1);
   localparam logic [8:0] LEN_EXTRA  = 9'(COMMAND_LENGTH + SIZE_DIGITS + 2);
   localparam logic [8:0] LEN_SHORT  = 9'(COMMAND_LENGTH);

   logic        is_timeout;
   logic        frame_end;
   status_type  status;
   logic [8:0]  frame_length;
   logic [4:0]  digit;
   logic        data_done;

   assign is_timeout = (req.cmd == CMD_TIMEOUT);
   assign digit      = hex_digit(req.byte_in);
   assign data_done  = {1'b0, state.byte_count} >= (DATA_BASE + {2'b00, state.size_value});

   always_comb begin
      frame_end    = 1'b0;
      status       = ST_BUSY;
      frame_length = 9'd0;
      if (is_timeout) begin
         frame_end = 1'b1;
         status    = ST_TIMEOUT;
      end else begin
         unique case (state.phase)
            PH_CMD, PH_SIZE, PH_DATA: begin
            end
            PH_FLAG: begin
               if (req.byte_in == 8'd0) begin
                  frame_end    = 1'b1;
                  status       = ST_OK;
                  frame_length = LEN_SHORT;
               end
            end
            PH_SEP: begin
               if (state.size_value == 8'd0 || state.size_value > max_data_length) begin
                  frame_end = 1'b1;
                  status    = ST_BADSIZE;
               end
            end
            default: begin
               frame_end = 1'b1;
               if (req.byte_in == 8'd0) begin
                  status       = ST_OK;
                  frame_length = {1'b0, state.size_value} + LEN_EXTRA;
               end else begin
                  status = ST_NOTERM;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_present       = !(is_timeout && state.phase == PH_CMD && state.byte_count == 9'd0);
      rsp.byte_out      = is_timeout ? 8'd0 : req.byte_in;
      rsp.position      = state.byte_count;
      rsp.frame_end     = frame_end;
      rsp.status        = status;
      rsp.frame_length  = frame_length;
   end

   always_comb begin
      state_next = state;
      if (frame_end) begin
         state_next.phase      = PH_CMD;
         state_next.byte_count = 9'd0;
         state_next.size_value = 8'd0;
         state_next.size_mode  = SZ_FIRST;
      end else begin
         state_next.byte_count = state.byte_count + 9'd1;
         unique case (state.phase)
            PH_CMD: begin
               if (state.byte_count >= CMD_LAST) begin
                  state_next.phase = PH_FLAG;
               end
            end
            PH_FLAG: begin
               state_next.phase = PH_SIZE;
            end
            PH_SIZE: begin
               if (state.size_mode != SZ_STOP) begin
                  if (digit[4]) begin
                     state_next.size_value = {state.size_value[3:0], digit[3:0]};
                     state_next.size_mode  = SZ_DIGITS;
                  end else if (state.size_mode == SZ_FIRST &&
                               (req.byte_in == " " || req.byte_in == "+")) begin
                     state_next.size_mode = SZ_SIGNED;
                  end else begin
                     state_next.size_mode = SZ_STOP;
                  end
               end
               if (state.byte_count >= SIZE_LAST) begin
                  state_next.phase = PH_SEP;
               end
            end
            PH_SEP: begin
               state_next.phase = PH_DATA;
            end
            PH_DATA: begin
               if (data_done) begin
                  state_next.phase = PH_TERM;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

/* sv/scfp_skid.sv */
// Two-entry result buffer: an output register backed by a skid register.
// The upstream stall comes straight from a flop; depends on scfp_pkg.
module scfp_skid
   import scfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_stall,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_stall
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_free;

   assign main_free = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for serial_command_frame_parser: directed frames, size limit
// extremes, receiver back-pressure and random frames, checked against an in-bench parser.
// Depends on scfp_pkg and the serial_command_frame_parser RTL.
module tb_top;
   import scfp_pkg::*;

   localparam int CMD_LEN       = DEF_COMMAND_LENGTH;
   localparam int SIZE_DIG      = DEF_SIZE_DIGITS;
   localparam int SIZE_END      = CMD_LEN + 1 + SIZE_DIG;
   localparam int DATA_START    = SIZE_END + 1;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 60;
   localparam int CYCLE_LIMIT   = 500000;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   req_type    req_data         = '0;
   logic       req_stall;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       rsp_stall        = 1'b0;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data   = '0;

   phase_type     frame_phase;
   logic [8:0]    frame_pos;
   logic [7:0]    size_acc;
   size_mode_type size_mode;
   logic [7:0]    size_limit;

   rsp_type awaited_echoes[$];
   rsp_type echo_front;
   int      mismatch_count = 0;
   int      cycle_count    = 0;
   int      beats_sent     = 0;
   int      stall_left     = 0;
   int      hold_left      = 0;
   bit      hold_pending   = 1'b0;
   bit      idle_off       = 1'b0;

   serial_command_frame_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_data         (req_data),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .rsp_stall        (rsp_stall),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return "0" + {4'd0, nib};
      return ($urandom_range(0, 1) ? "A" : "a") + {4'd0, nib} - 8'd10;
   endfunction

   function automatic logic [7:0] junk_char(input bit first);
      case ($urandom_range(0, first ? 5 : 7))
         0: return "-";
         1: return "g";
         2: return "Z";
         3: return ".";
         4: return 8'h00;
         5: return 8'hff;
         6: return " ";
         default: return "+";
      endcase
   endfunction

   task automatic restart_frame();
      frame_phase = PH_CMD;
      frame_pos   = 9'd0;
      size_acc    = 8'd0;
      size_mode   = SZ_FIRST;
   endtask

   task automatic parse_beat(input req_type beat);
      rsp_type echo;
      int      digit;
      echo          = '0;
      echo.byte_out = beat.byte_in;
      echo.position = frame_pos;
      echo.status   = ST_BUSY;
      if (beat.cmd == CMD_TIMEOUT) begin
         if (frame_phase == PH_CMD && frame_pos == 9'd0) return;
         echo.byte_out  = 8'd0;
         echo.frame_end = 1'b1;
         echo.status    = ST_TIMEOUT;
         awaited_echoes.push_back(echo);
         restart_frame();
         return;
      end
      case (frame_phase)
         PH_CMD: begin
            if (int'(frame_pos) + 1 >= CMD_LEN) frame_phase = PH_FLAG;
         end
         PH_FLAG: begin
            if (beat.byte_in == 8'd0) begin
               echo.frame_end    = 1'b1;
               echo.status       = ST_OK;
               echo.frame_length = 9'(CMD_LEN);
            end else begin
               frame_phase = PH_SIZE;
            end
         end
         PH_SIZE: begin
            digit = -1;
            if (beat.byte_in >= "0" && beat.byte_in <= "9") begin
               digit = int'(beat.byte_in - "0");
            end else if (beat.byte_in >= "a" && beat.byte_in <= "f") begin
               digit = int'(beat.byte_in - "a") + 10;
            end else if (beat.byte_in >= "A" && beat.byte_in <= "F") begin
               digit = int'(beat.byte_in - "A") + 10;
            end
            if (size_mode != SZ_STOP) begin
               if (digit >= 0) begin
                  size_acc  = {size_acc[3:0], 4'(digit)};
                  size_mode = SZ_DIGITS;
               end else if (size_mode == SZ_FIRST &&
                            (beat.byte_in == " " || beat.byte_in == "+")) begin
                  size_mode = SZ_SIGNED;
               end else begin
                  size_mode = SZ_STOP;
               end
            end
            if (int'(frame_pos) + 1 >= SIZE_END) frame_phase = PH_SEP;
         end
         PH_SEP: begin
            if (size_acc == 8'd0 || size_acc > size_limit) begin
               echo.frame_end = 1'b1;
               echo.status    = ST_BADSIZE;
            end else begin
               frame_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            if (int'(frame_pos) + 1 >= DATA_START + int'(size_acc)) frame_phase = PH_TERM;
         end
         default: begin
            echo.frame_end = 1'b1;
            if (beat.byte_in == 8'd0) begin
               echo.status       = ST_OK;
               echo.frame_length = 9'(int'(size_acc) + CMD_LEN + SIZE_DIG + 2);
            end else begin
               echo.status = ST_NOTERM;
            end
         end
      endcase
      awaited_echoes.push_back(echo);
      if (echo.frame_end) restart_frame();
      else frame_pos = frame_pos + 9'd1;
   endtask

   // Every beat is offered at a falling edge and counts as accepted at the first
   // rising edge that sees the DUT not stalling.
   task automatic send_beat(input cmd_type cmd, input logic [7:0] value);
      req_type beat;
      int      gap;
      beat.cmd     = cmd;
      beat.byte_in = value;
      gap = idle_off ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_beat(beat);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] flag, s0, s1, input int data_n,
                             input logic [7:0] term, input int cut);
      logic [7:0] seq[$];
      repeat (CMD_LEN) seq.push_back(8'($urandom));
      seq.push_back(flag);
      if (flag != 8'd0) begin
         seq.push_back(s0);
         seq.push_back(s1);
         seq.push_back(8'($urandom));
         if (data_n >= 0) begin
            repeat (data_n) seq.push_back(8'($urandom));
            seq.push_back(term);
         end
      end
      foreach (seq[i]) begin
         if (i == cut) begin
            send_beat(CMD_TIMEOUT, 8'($urandom));
            return;
         end
         send_beat(CMD_BYTE, seq[i]);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_echoes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      size_limit = value;
   endtask

   task automatic random_frame();
      int         pick;
      int         value;
      int         data_n;
      int         cut;
      logic [7:0] s0;
      logic [7:0] s1;
      logic [7:0] flag;
      logic [7:0] term;
      // A frame left open by noise is dropped with a timeout so the next one starts clean.
      if (frame_phase != PH_CMD || frame_pos != 9'd0) send_beat(CMD_TIMEOUT, 8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 75) value = $urandom_range(1, 12);
      else if (pick < 85) value = $urandom_range(13, 40);
      else if (pick < 91) value = $urandom_range(0, 255);
      else if (pick < 95) value = (size_limit == 8'd255) ? 255 :
                                  int'(size_limit) + $urandom_range(0, 1);
      else value = 0;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         s0 = hex_char(value[7:4]);
         s1 = hex_char(value[3:0]);
      end else if (pick < 75) begin
         value = value % 16;
         s0    = $urandom_range(0, 1) ? " " : "+";
         s1    = hex_char(value[3:0]);
      end else if (pick < 85) begin
         value = value % 16;
         s0    = hex_char(value[3:0]);
         s1    = junk_char(1'b0);
      end else if (pick < 92) begin
         value = 0;
         s0    = junk_char(1'b1);
         s1    = hex_char(4'($urandom));
      end else begin
         s0    = 8'($urandom);
         s1    = 8'($urandom);
         value = $urandom_range(1, 6);
      end
      data_n = (value == 0 || value > int'(size_limit)) ? -1 : value;
      flag   = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      term   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      cut    = ($urandom_range(0, 19) == 0) ?
               $urandom_range(0, DATA_START + (data_n > 0 ? data_n : 0)) : -1;
      send_frame(flag, s0, s1, data_n, term, cut);
   endtask

   task automatic test_directed();
      send_beat(CMD_TIMEOUT, 8'h5a);
      for (int i = 0; i < CMD_LEN; i++) send_beat(CMD_BYTE, i[0] ? 8'hff : 8'h00);
      send_beat(CMD_BYTE, 8'h00);
      send_frame(8'ha5, " ", "1", 1, 8'h00, -1);
      send_frame(8'hff, "+", "a", 10, 8'h00, -1);
      send_frame(8'h01, "0", "C", 12, 8'h00, -1);
      send_frame(8'h02, "2", "z", 2, 8'h5a, -1);
      send_frame(8'h80, "3", " ", 3, 8'hff, -1);
      send_frame(8'h03, "-", "5", -1, 8'h00, -1);
      send_frame(8'h04, "f", "F", -1, 8'h00, -1);
      send_frame(8'h05, "0", "0", -1, 8'h00, -1);
      send_frame(8'h06, "0", "3", 3, 8'h00, DATA_START + 1);
      send_frame(8'h07, "1", "0", 16, 8'h00, 4);
   endtask

   task automatic test_limit_extremes();
      write_limit(8'd1);
      send_frame(8'h11, "0", "1", 1, 8'h00, -1);
      send_frame(8'h12, "0", "2", -1, 8'h00, -1);
      write_limit(8'd255);
      send_frame(8'h13, "F", "F", 255, 8'h00, -1);
      send_frame(8'h14, "0", "0", -1, 8'h00, -1);
   endtask

   // The receiver holds off long enough for the DUT to fill up and stall its input.
   task automatic test_backpressure();
      int start;
      settle();
      idle_off = 1'b1;
      @(posedge clock);
      hold_pending = 1'b1;
      @(negedge clock);
      start = beats_sent;
      while (beats_sent - start < 40) random_frame();
      idle_off = 1'b0;
   endtask

   task automatic test_random_frames(input int target);
      int start;
      start = beats_sent;
      while (beats_sent - start < target) begin
         if ($urandom_range(0, 19) == 0) idle_off = !idle_off;
         if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 4))
               send_beat(cmd_type'($urandom_range(0, 1)), 8'($urandom));
         end else begin
            random_frame();
         end
      end
      idle_off = 1'b0;
   endtask

   task automatic test_random_limits();
      write_limit(DEF_MAX_DATA_LENGTH);
      test_random_frames(350);
      write_limit(8'd4);
      test_random_frames(250);
      write_limit(8'($urandom_range(1, 255)));
      test_random_frames(350);
      write_limit(8'd255);
      test_random_frames(250);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!idle_off) stall_left = idle_length();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_echoes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected beat: byte=%h pos=%0d end=%0b status=%0d len=%0d",
                        rsp_data.byte_out, rsp_data.position, rsp_data.frame_end,
                        rsp_data.status, rsp_data.frame_length);
         end else begin
            echo_front = awaited_echoes.pop_front();
            if (rsp_data.byte_out !== echo_front.byte_out ||
                rsp_data.position !== echo_front.position ||
                rsp_data.frame_end !== echo_front.frame_end ||
                rsp_data.status !== echo_front.status ||
                rsp_data.frame_length !== echo_front.frame_length) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected byte=%h pos=%0d end=%0b status=%0d len=%0d,",
                           echo_front.byte_out, echo_front.position, echo_front.frame_end,
                           echo_front.status, echo_front.frame_length,
                           " got byte=%h pos=%0d end=%0b status=%0d len=%0d",
                           rsp_data.byte_out, rsp_data.position, rsp_data.frame_end,
                           rsp_data.status, rsp_data.frame_length);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      restart_frame();
      size_limit = DEF_MAX_DATA_LENGTH;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_limit_extremes();
      test_backpressure();
      test_random_limits();
      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && awaited_echoes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
